/* rtl/index_free_list_allocator_macros.svh */
// ============================================================================
// Assertion macros for the index free-list allocator
// Shared shorthand for clocked checks that are disabled during reset.
// ============================================================================
`ifndef INDEX_FREE_LIST_ALLOCATOR_MACROS_SVH
`define INDEX_FREE_LIST_ALLOCATOR_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define IFLA_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define IFLA_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ifla_pkg.sv */
// ============================================================================
// ifla_pkg
// Types and constants of the index free-list allocator.
// ============================================================================
package ifla_pkg;

    // Default number of indices in the pool.
    localparam int unsigned IFLA_POOL_DEPTH = 64;

    // Widths of the item fields.
    localparam int unsigned REL_IDX_W   = 7;
    localparam int unsigned GRANT_IDX_W = 6;
    localparam int unsigned USED_W      = 7;

    // Operation codes.
    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_EMPTY    = 2'd1,
        STATUS_RANGE    = 2'd2,
        STATUS_NOT_HELD = 2'd3
    } status_t;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

endpackage

/* rtl/ifla_ram.sv */
// ============================================================================
// ifla_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module ifla_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/index_free_list_allocator.sv */
// The result is registered: an accepted item enters the lookup state while both RAMs are read, and
// is resolved into the output register once the output is free; no new item is taken during lookup.
// Reset: head, count, high-water mark, state and output valid clear at once; RAMs are not
// cleared: entries at or above the high-water mark are treated as free and not held.
// No clearing pass: the block takes items from the first cycle after reset.
// ============================================================================
// index_free_list_allocator
// LIFO free-list index allocator with its link and held flags kept in RAM.
// ============================================================================
`include "index_free_list_allocator_macros.svh"

module index_free_list_allocator
    import ifla_pkg::*;
#(
    parameter int unsigned POOL_DEPTH = IFLA_POOL_DEPTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   cmd,
    input  logic [REL_IDX_W-1:0]   release_index,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [GRANT_IDX_W-1:0] granted_index,
    output logic [1:0]             status,
    output logic [USED_W-1:0]      in_use_count
);

    localparam int unsigned HEAD_W = $clog2(POOL_DEPTH + 1);
    localparam int unsigned IDX_W  = $clog2(POOL_DEPTH);
    localparam int unsigned CMP_W  = (HEAD_W > REL_IDX_W) ? HEAD_W : REL_IDX_W;
    localparam logic [HEAD_W-1:0] DEPTH_H = HEAD_W'(POOL_DEPTH);
    localparam logic [CMP_W-1:0]  DEPTH_C = CMP_W'(POOL_DEPTH);

    state_t                   state_reg, state_next;
    logic [HEAD_W-1:0]        head_reg, head_next;
    logic [HEAD_W-1:0]        hw_reg, hw_next;
    logic [HEAD_W-1:0]        count_reg, count_next;
    logic                     op_cmd_reg;
    logic [REL_IDX_W-1:0]     op_idx_reg;
    logic                     out_valid_reg, out_valid_next;
    logic [GRANT_IDX_W-1:0]   granted_reg, granted_next;
    status_t                  status_reg, status_next;
    logic [USED_W-1:0]        used_reg, used_next;

    logic                     accept;
    logic                     out_free;
    logic                     resolve;
    logic                     grant_ok;
    logic [CMP_W-1:0]         rel_ext;
    logic [CMP_W-1:0]         op_ext;
    logic [CMP_W-1:0]         head_ext;
    logic [CMP_W-1:0]         hw_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic                     fresh_head;
    logic                     held;

    logic                     link_we;
    logic [IDX_W-1:0]         link_waddr;
    logic [HEAD_W-1:0]        link_wdata;
    logic [IDX_W-1:0]         link_raddr;
    logic [HEAD_W-1:0]        link_rdata;
    logic                     flag_we;
    logic [IDX_W-1:0]         flag_waddr;
    logic [0:0]               flag_wdata;
    logic [IDX_W-1:0]         flag_raddr;
    logic [0:0]               flag_rdata;

    // Handshake.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign resolve  = (state_reg == ST_LOOKUP) && out_free;

    // A successful acquire being resolved this cycle.
    assign grant_ok = resolve && (op_cmd_reg == CMD_ACQUIRE) && (status_next == STATUS_OK);

    // Extended views for range compares and output truncation.
    assign rel_ext  = CMP_W'(release_index);
    assign op_ext   = CMP_W'(op_idx_reg);
    assign head_ext = CMP_W'(head_reg);
    assign hw_ext   = CMP_W'(hw_reg);
    assign cnt_ext  = CMP_W'(count_next);

    // Entries below the high-water mark have been written; at or above it RAM contents are ignored.
    assign fresh_head = (head_reg >= hw_reg);
    assign held       = (op_ext < hw_ext) && flag_rdata[0];

    // Both RAMs are read when an item is taken in.
    assign link_raddr = head_reg[IDX_W-1:0];
    assign flag_raddr = rel_ext[IDX_W-1:0];

    ifla_ram #(
        .WIDTH (HEAD_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (accept),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    ifla_ram #(
        .WIDTH (1),
        .DEPTH (POOL_DEPTH)
    ) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (accept),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

    // Resolve the item once the read data is back and the output slot is free.
    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        hw_next      = hw_reg;
        count_next   = count_reg;
        granted_next = granted_reg;
        status_next  = status_reg;
        link_we      = 1'b0;
        link_waddr   = op_ext[IDX_W-1:0];
        link_wdata   = head_reg;
        flag_we      = 1'b0;
        flag_waddr   = op_ext[IDX_W-1:0];
        flag_wdata   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next   = ST_IDLE;
                    granted_next = '0;
                    status_next  = STATUS_OK;
                    if (op_cmd_reg == CMD_ACQUIRE)
                    begin
                        if ((count_reg >= DEPTH_H) || (head_reg >= DEPTH_H))
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            granted_next = head_ext[GRANT_IDX_W-1:0];
                            head_next    = fresh_head ? (head_reg + HEAD_W'(1)) : link_rdata;
                            if (fresh_head)
                            begin
                                hw_next = head_reg + HEAD_W'(1);
                            end
                            flag_we    = 1'b1;
                            flag_waddr = head_reg[IDX_W-1:0];
                            flag_wdata = 1'b1;
                            count_next = count_reg + HEAD_W'(1);
                        end
                    end
                    else if (op_ext >= DEPTH_C)
                    begin
                        status_next = STATUS_RANGE;
                    end
                    else if (!held)
                    begin
                        status_next = STATUS_NOT_HELD;
                    end
                    else
                    begin
                        link_we   = 1'b1;
                        flag_we   = 1'b1;
                        head_next = op_ext[HEAD_W-1:0];
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - HEAD_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: loaded on resolve, cleared when taken.
    always_comb
    begin
        used_next = used_reg;
        if (resolve)
        begin
            out_valid_next = 1'b1;
            used_next      = cnt_ext[USED_W-1:0];
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            hw_reg        <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            hw_reg        <= hw_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_cmd_reg <= cmd;
            op_idx_reg <= release_index;
        end
        granted_reg <= granted_next;
        status_reg  <= status_next;
        used_reg    <= used_next;
    end

    assign out_valid     = out_valid_reg;
    assign granted_index = granted_reg;
    assign status        = status_reg;
    assign in_use_count  = used_reg;

    // Checks.
    `IFLA_ASSERT(a_count_bound, count_reg <= DEPTH_H, "held count exceeds the pool depth")
    `IFLA_ASSERT(a_hw_bound, hw_reg <= DEPTH_H, "high-water mark exceeds the pool depth")
    `IFLA_IMPLY(a_accept_lookup, accept, state_reg == ST_LOOKUP, "accepted item not looked up")
    `IFLA_IMPLY(a_resolve_out, resolve, out_valid_reg, "resolved item did not reach the output")
    `IFLA_IMPLY(a_grant_count, grant_ok, count_reg == $past(count_reg) + HEAD_W'(1),
                "grant did not raise the held count")

endmodule
